>>> hdl/tsb_pkg.sv
package tsb_pkg;

  localparam int unsigned HANDLE_W       = 32;
  localparam int unsigned CAP_W          = 14;
  localparam int unsigned SLOT_W         = 5;
  localparam int unsigned SLOT_COUNT_DEF = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 14'd1000;

  localparam logic MODE_DRAW = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                cmp_en;
    logic                wr_en;
    logic [HANDLE_W-1:0] handle;
  } cell_ctrl_t;

endpackage

>>> hdl/tsb_in_if.sv
interface tsb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [tsb_pkg::HANDLE_W-1:0]  texture_handle;

  modport source (output valid, output mode, output texture_handle, input ready);
  modport sink   (input valid, input mode, input texture_handle, output ready);
endinterface

>>> hdl/tsb_out_if.sv
interface tsb_out_if;
  logic                       valid;
  logic                       ready;
  logic [tsb_pkg::SLOT_W-1:0] slot;
  logic                       slot_new;
  logic                       slots_restarted;
  logic                       flushed;
  logic [tsb_pkg::CAP_W-1:0]  flushed_quads;
  logic [tsb_pkg::CAP_W-1:0]  quad_position;

  modport source (output valid, output slot, output slot_new, output slots_restarted,
                  output flushed, output flushed_quads, output quad_position,
                  input ready);
  modport sink   (input valid, input slot, input slot_new, input slots_restarted,
                  input flushed, input flushed_quads, input quad_position,
                  output ready);
endinterface

>>> hdl/tsb_cell.sv
module tsb_cell #(
  parameter int unsigned INDEX  = 0,
  parameter int unsigned IDX_W  = 5,
  parameter int unsigned USED_W = 6
) (
  input  logic                    clk,
  input  tsb_pkg::cell_ctrl_t     ctrl,
  input  logic [IDX_W-1:0]        wr_idx,
  input  logic [USED_W-1:0]       used,
  input  logic                    hit_in,
  output logic                    hit_out,
  output logic                    match
);

  logic [tsb_pkg::HANDLE_W-1:0] handle_r;
  logic                         match_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (wr_idx == IDX_W'(INDEX))) begin
      handle_r <= ctrl.handle;
    end
    if (ctrl.cmp_en) begin
      match_r <= (handle_r == ctrl.handle) && (used > USED_W'(INDEX));
    end
  end

  // lowest hit wins: a cell only reports a hit when no cell below it has one
  assign match   = match_r && !hit_in;
  assign hit_out = match_r || hit_in;

endmodule

>>> hdl/texture_slot_batcher.sv
// Texture slot allocator and quad batcher. Each draw request carries a texture
// handle; it is matched against the filled part of a slot table held in a row
// of cells, or appended. A full table flushes the batch and restarts at slot 0,
// and a batch that has reached batch_capacity quads is flushed before the new
// quad joins. An end-scene request flushes the pending quads. One result per
// request. A request first has every cell compare its stored handle as it is
// accepted; then, in the match state, the lowest hit is picked and the counters and
// table are updated. A new request is taken once the previous one has left the
// match state, and a result waiting in the output register stalls it only when the
// next result is ready to be written. The user must write batch_capacity through
// cfg_we/cfg_data only while no request is in flight; the block does not enforce it.
module texture_slot_batcher #(
  parameter int unsigned SLOT_COUNT = tsb_pkg::SLOT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  tsb_in_if.sink                   in_ch,
  tsb_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [tsb_pkg::CAP_W-1:0] cfg_data
);

  localparam int unsigned IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned USED_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CW     = tsb_pkg::CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MATCH = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   cap_r;
  logic [USED_W-1:0]               used_r, used_nxt;
  logic [CW-1:0]                   pend_r, pend_nxt;
  logic                            mode_r;
  logic [tsb_pkg::HANDLE_W-1:0]    handle_r;

  logic                            out_valid_r;
  logic [tsb_pkg::SLOT_W-1:0]      slot_r, slot_nxt;
  logic                            new_r, new_nxt;
  logic                            rst_tab_r, rst_tab_nxt;
  logic                            fl_r, fl_nxt;
  logic [CW-1:0]                   flq_r, flq_nxt;
  logic [CW-1:0]                   pos_r, pos_nxt;

  tsb_pkg::cell_ctrl_t             ctrl;
  logic [IDX_W-1:0]                wr_idx;
  logic [SLOT_COUNT-1:0]           match;
  logic [SLOT_COUNT:0]             hit_chain;
  logic                            found;
  logic [IDX_W-1:0]                hit_idx;
  logic                            accept, update;
  logic [CW-1:0]                   base;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign update    = (state_r == ST_MATCH) && (!out_valid_r || out_ch.ready);

  assign hit_chain[0] = 1'b0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    tsb_cell #(
      .INDEX  (g),
      .IDX_W  (IDX_W),
      .USED_W (USED_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .wr_idx  (wr_idx),
      .used    (used_r),
      .hit_in  (hit_chain[g]),
      .hit_out (hit_chain[g+1]),
      .match   (match[g])
    );
  end

  assign found = hit_chain[SLOT_COUNT];

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    pend_nxt    = pend_r;
    slot_nxt    = '0;
    new_nxt     = 1'b0;
    rst_tab_nxt = 1'b0;
    flq_nxt     = '0;
    pos_nxt     = '0;
    wr_idx      = hit_idx;
    base        = pend_r;
    ctrl.cmp_en = accept;
    ctrl.wr_en  = 1'b0;
    ctrl.handle = accept ? in_ch.texture_handle : handle_r;

    if (mode_r == tsb_pkg::MODE_END) begin
      flq_nxt  = pend_r;
      pend_nxt = '0;
    end else begin
      if (pend_r >= cap_r) begin
        flq_nxt = pend_r;
        base    = '0;
      end
      if (found) begin
        wr_idx = hit_idx;
      end else if (used_r >= USED_W'(SLOT_COUNT)) begin
        // table full: flush and restart at slot 0
        if (base != '0) begin
          flq_nxt = base;
        end
        base        = '0;
        rst_tab_nxt = 1'b1;
        new_nxt     = 1'b1;
        wr_idx      = '0;
        used_nxt    = USED_W'(1);
        ctrl.wr_en  = update;
      end else begin
        new_nxt    = 1'b1;
        wr_idx     = IDX_W'(used_r);
        used_nxt   = used_r + USED_W'(1);
        ctrl.wr_en = update;
      end
      slot_nxt = tsb_pkg::SLOT_W'(wr_idx);
      pos_nxt  = base;
      pend_nxt = base + CW'(1);
    end
    fl_nxt = (flq_nxt != '0);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (update) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= tsb_pkg::CAP_RESET;
      used_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (update) begin
        used_r      <= used_nxt;
        pend_r      <= pend_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_ch.mode;
      handle_r <= in_ch.texture_handle;
    end
    if (update) begin
      slot_r    <= slot_nxt;
      new_r     <= new_nxt;
      rst_tab_r <= rst_tab_nxt;
      fl_r      <= fl_nxt;
      flq_r     <= flq_nxt;
      pos_r     <= pos_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.slot            = slot_r;
  assign out_ch.slot_new        = new_r;
  assign out_ch.slots_restarted = rst_tab_r;
  assign out_ch.flushed         = fl_r;
  assign out_ch.flushed_quads   = flq_r;
  assign out_ch.quad_position   = pos_r;

endmodule

>>> hdl/tsb_checker.sv
module tsb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tsb_pkg::SLOT_W-1:0] out_slot,
  input logic                       out_slot_new,
  input logic                       out_slots_restarted,
  input logic                       out_flushed,
  input logic [tsb_pkg::CAP_W-1:0]  out_flushed_quads
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // flush flag agrees with the flushed quad count
  a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_flushed == (out_flushed_quads != '0)))
    else $error("flushed flag and quad count disagree");

  // a restarted table always hands out slot 0 as a new entry
  a_restart_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slots_restarted |-> out_slot_new && (out_slot == '0))
    else $error("restart without a new entry in slot 0");

endmodule

bind texture_slot_batcher tsb_checker u_tsb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_slot            (out_ch.slot),
  .out_slot_new        (out_ch.slot_new),
  .out_slots_restarted (out_ch.slots_restarted),
  .out_flushed         (out_ch.flushed),
  .out_flushed_quads   (out_ch.flushed_quads)
);
